// ----- sv/usc_pkg.sv -----
// Shared types, constants and helper functions of the 2x cubic B-spline upscaler.
package usc_pkg;

	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int COORD_W    = 10;
	localparam int PIX_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

	localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 10'd320;
	localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 10'd240;

	localparam int LANES      = 4;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

	localparam int WGT_W  = 6;
	localparam int VSUM_W = 12;
	localparam int ACC_W  = 18;

	// one line-store read with the bookkeeping of the output it belongs to
	typedef struct packed {
		logic                      valid;
		logic                      first;
		logic                      last;
		logic                      run_last;
		logic [WGT_W-1:0]          wx;
		logic                      y_odd;
		logic [LANES-1:0][1:0]     lanes;
		logic [COORD_W-1:0]        col;
		logic [COORD_W-1:0]        row;
	} tap_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [PIX_W-1:0]   pix;
		logic               run_last;
	} result_t;

	// B-spline weights over 48: even 8,32,8,0; odd 1,23,23,1
	function automatic logic [WGT_W-1:0] axis_weight(input logic odd, input logic [1:0] n);
		logic [WGT_W-1:0] w;
		if (odd) begin
			w = (n == 2'd0 || n == 2'd3) ? 6'd1 : 6'd23;
		end else begin
			w = (n == 2'd1) ? 6'd32 : ((n == 2'd3) ? 6'd0 : 6'd8);
		end
		return w;
	endfunction

	// floor(s / 2304): shift by 256, then divide by 9 via reciprocal and one fixup
	function automatic logic [5:0] div2304(input logic [ACC_W-1:0] s);
		logic [9:0]  y;
		logic [18:0] prod;
		logic [6:0]  q;
		logic [10:0] qx9;
		logic [10:0] rem;
		y    = s[ACC_W-1:8];
		prod = 19'(y) * 19'd455;
		q    = prod[18:12];
		qx9  = 11'(q) * 11'd9;
		rem  = {1'b0, y} - qx9;
		if (rem >= 11'd9) begin
			q = q + 7'd1;
		end
		return 6'(q);
	endfunction

endpackage

// ----- sv/usc_stream_if.sv -----
// Valid/ready channel interfaces for source pixels and upscaled results.
interface usc_pixel_if
	import usc_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] source_pixel;

	modport source(output valid, output source_pixel, input ready);
	modport sink(input valid, input source_pixel, output ready);
endinterface

interface usc_result_if
	import usc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] out_column;
	logic [COORD_W-1:0] out_row;
	logic [PIX_W-1:0]   out_pixel;
	logic               run_last;

	modport source(output valid, output out_column, output out_row, output out_pixel,
		output run_last, input ready);
	modport sink(input valid, input out_column, input out_row, input out_pixel,
		input run_last, output ready);
endinterface

// ----- sv/usc_line_store.sv -----
// Line store: one word per source column holding the four most recent rows.
module usc_line_store
	import usc_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [$clog2(MAX_WIDTH)-1:0]      waddr,
	input  logic [1:0]                        wlane,
	input  logic [PIX_W-1:0]                  wdata,
	input  logic [$clog2(MAX_WIDTH)-1:0]      raddr,
	output logic [LANES-1:0][PIX_W-1:0]       rdata
);

	logic [LANES-1:0][PIX_W-1:0] mem_q [MAX_WIDTH];
	logic [LANES-1:0][PIX_W-1:0] rd_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr][wlane] <= wdata;
		end
		rd_s1 <= mem_q[raddr];
	end

	assign rdata = rd_s1;

endmodule

// ----- sv/usc_seq.sv -----
// Sequencer: frame counters, line-store writes and per-output tap read issue.
module usc_seq
	import usc_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [$clog2(MAX_WIDTH):0]        w_eff,
	input  logic [$clog2(MAX_HEIGHT):0]       h_eff,
	input  logic                              cfg_we,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PIX_W-1:0]                  in_pixel,
	output logic                              mem_we,
	output logic [$clog2(MAX_WIDTH)-1:0]      mem_waddr,
	output logic [1:0]                        mem_wlane,
	output logic [PIX_W-1:0]                  mem_wdata,
	output logic [$clog2(MAX_WIDTH)-1:0]      mem_raddr,
	output tap_t                              tap,
	input  logic                              out_pop
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = CW + 1;
	localparam int YW = RW + 1;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RUN  = 1'b1;

	logic              state_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [XW-1:0]     i_q, istart_q, iend_q;
	logic [YW-1:0]     j_q, jend_q;
	logic [1:0]        n_q;
	logic [FIFO_CW-1:0] pend_q;

	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;
	logic          c_last, r_last, accept, empty, go, last_n, i_end, j_end;
	logic [XW-1:0] c2, istart, iend;
	logic [YW-1:0] r2, jstart, jend;

	logic [CW-1:0] kx, sx;
	logic [CW:0]   tx, txm1;
	logic [RW-1:0] ky, y0, y2, y3;
	logic [RW:0]   t2, t3;

	assign wm1    = CW'(w_eff - 1'b1);
	assign hm1    = RW'(h_eff - 1'b1);
	assign c_last = (col_q == wm1);
	assign r_last = (row_q == hm1);
	assign in_ready = (state_q == S_IDLE);
	assign accept = in_ready && in_valid;

	assign c2     = {col_q, 1'b0};
	assign r2     = {row_q, 1'b0};
	assign istart = (c2 >= XW'(3)) ? c2 - XW'(3) : '0;
	assign jstart = (r2 >= YW'(3)) ? r2 - YW'(3) : '0;
	assign iend   = c_last ? {wm1, 1'b1} : {col_q - 1'b1, 1'b0};
	assign jend   = r_last ? {hm1, 1'b1} : {row_q - 1'b1, 1'b0};
	assign empty  = (col_q == '0 && !c_last) || (row_q == '0 && !r_last);

	assign mem_we    = accept;
	assign mem_waddr = col_q;
	assign mem_wlane = row_q[1:0];
	assign mem_wdata = in_pixel;

	// horizontal tap, clamped to the frame
	assign kx   = i_q[XW-1:1];
	assign tx   = (CW+1)'(kx) + (CW+1)'(n_q);
	assign txm1 = tx - 1'b1;
	assign sx   = (tx == '0) ? '0 : ((txm1 > (CW+1)'(wm1)) ? wm1 : CW'(txm1));
	assign mem_raddr = sx;

	// vertical taps, clamped to the frame
	assign ky = j_q[YW-1:1];
	assign y0 = (ky == '0) ? '0 : ky - 1'b1;
	assign t2 = (RW+1)'(ky) + 1'b1;
	assign t3 = (RW+1)'(ky) + 2'd2;
	assign y2 = (t2 > (RW+1)'(hm1)) ? hm1 : RW'(t2);
	assign y3 = (t3 > (RW+1)'(hm1)) ? hm1 : RW'(t3);

	assign last_n = i_q[0] ? (n_q == 2'd3) : (n_q == 2'd2);
	assign i_end  = (i_q == iend_q);
	assign j_end  = (j_q == jend_q);
	assign go     = (state_q == S_RUN) && (n_q != 2'd0 || pend_q < FIFO_CW'(FIFO_DEPTH));

	always_comb begin
		tap.valid    = go;
		tap.first    = (n_q == 2'd0);
		tap.last     = last_n;
		tap.run_last = last_n && i_end && j_end;
		tap.wx       = axis_weight(i_q[0], n_q);
		tap.y_odd    = j_q[0];
		tap.lanes[0] = y0[1:0];
		tap.lanes[1] = ky[1:0];
		tap.lanes[2] = y2[1:0];
		tap.lanes[3] = y3[1:0];
		tap.col      = COORD_W'(i_q);
		tap.row      = COORD_W'(j_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			col_q   <= '0;
			row_q   <= '0;
			pend_q  <= '0;
			n_q     <= '0;
		end else begin
			pend_q <= pend_q + FIFO_CW'(go && n_q == 2'd0) - FIFO_CW'(out_pop);
			if (cfg_we) begin
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (c_last) begin
					col_q <= '0;
					row_q <= r_last ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && !empty) begin
						state_q <= S_RUN;
						n_q     <= '0;
					end
				end
				S_RUN: begin
					if (go) begin
						if (last_n) begin
							n_q <= '0;
							if (i_end && j_end) begin
								state_q <= S_IDLE;
							end
						end else begin
							n_q <= n_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			i_q      <= istart;
			istart_q <= istart;
			iend_q   <= iend;
			j_q      <= jstart;
			jend_q   <= jend;
		end else if (go && last_n) begin
			if (i_end) begin
				i_q <= istart_q;
				j_q <= j_q + 1'b1;
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

endmodule

// ----- sv/usc_filter.sv -----
// Filter datapath: vertical sums, horizontal accumulation, scaling and RGB565 packing.
module usc_filter
	import usc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  tap_t                        tap,
	input  logic [LANES-1:0][PIX_W-1:0] rdata,
	output result_t                     res,
	output logic                        res_valid
);

	tap_t                     tag_s1, tag_s2;
	logic [2:0][VSUM_W-1:0]   v_nx, v_s2;
	logic [2:0][ACC_W-1:0]    sum, acc_q, fin_s3;
	logic                     fin_valid_s3;
	logic [COORD_W-1:0]       col_s3, row_s3;
	logic                     run_last_s3;

	always_comb begin
		logic [PIX_W-1:0] p;
		logic [5:0]       ch;
		for (int c = 0; c < 3; c++) begin
			v_nx[c] = '0;
			for (int m = 0; m < LANES; m++) begin
				p = rdata[tag_s1.lanes[m]];
				if (c == 0) begin
					ch = 6'(p[15:11]);
				end else if (c == 1) begin
					ch = p[10:5];
				end else begin
					ch = 6'(p[4:0]);
				end
				if (m == 3 && !tag_s1.y_odd) begin
					ch = '0;
				end
				v_nx[c] = v_nx[c] + VSUM_W'(ch) * VSUM_W'(axis_weight(tag_s1.y_odd, 2'(m)));
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = (tag_s2.first ? '0 : acc_q[c]) + ACC_W'(v_s2[c]) * ACC_W'(tag_s2.wx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			tag_s2       <= '0;
			fin_valid_s3 <= 1'b0;
		end else begin
			tag_s1       <= tap;
			tag_s2       <= tag_s1;
			fin_valid_s3 <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		v_s2 <= v_nx;
		if (tag_s2.valid) begin
			acc_q <= sum;
			if (tag_s2.last) begin
				fin_s3      <= sum;
				col_s3      <= tag_s2.col;
				row_s3      <= tag_s2.row;
				run_last_s3 <= tag_s2.run_last;
			end
		end
	end

	always_comb begin
		logic [5:0] qr, qg, qb;
		qr = div2304(fin_s3[0]);
		qg = div2304(fin_s3[1]);
		qb = div2304(fin_s3[2]);
		res.col      = col_s3;
		res.row      = row_s3;
		res.pix      = {qr[4:0], qg, qb[4:0]};
		res.run_last = run_last_s3;
	end

	assign res_valid = fin_valid_s3;

endmodule

// ----- sv/bicubic_2x_upscaler_rgb565.sv -----
// Top level of the 2x cubic B-spline RGB565 upscaler with line store and result queue.
//
//  channel  dir  beat                                         accepted when
//  src      in   source_pixel                                 src.valid && src.ready
//  dst      out  out_column, out_row, out_pixel, run_last     dst.valid && dst.ready
//  cfg      in   cfg_index, cfg_data                          cfg_we
//
// Each output pixel costs one line-store read per horizontal tap: three reads for an
// even output column, four for an odd one. A source pixel is taken only while idle,
// and all of its 0 to 25 outputs are issued before the next is taken. Results queue
// in a 4-entry buffer; issue pauses while four results are in flight or queued.
// Reset loads 320x240 and clears the counters; the line store needs no clearing.
module bicubic_2x_upscaler_rgb565
	import usc_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	usc_pixel_if.sink             src,
	usc_result_if.source          dst
);

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int EXW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
	localparam int EYW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;

	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [EXW-1:0]        wext;
	logic [EYW-1:0]        hext;
	logic [CW:0]           w_eff;
	logic [RW:0]           h_eff;

	logic                        mem_we;
	logic [CW-1:0]               mem_waddr, mem_raddr;
	logic [1:0]                  mem_wlane;
	logic [PIX_W-1:0]            mem_wdata;
	logic [LANES-1:0][PIX_W-1:0] rdata;
	tap_t                        tap;
	result_t                     res;
	logic                        res_valid;

	result_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0]   wr_q, rd_q;
	logic [FIFO_CW-1:0]   cnt_q;
	logic                 pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= FRAME_WIDTH_RST;
			height_q <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				width_q <= cfg_data;
			end else if (cfg_index == REG_FRAME_HEIGHT) begin
				height_q <= cfg_data;
			end
		end
	end

	assign wext  = EXW'(width_q);
	assign hext  = EYW'(height_q);
	assign w_eff = (wext == '0) ? (CW+1)'(1) :
		((wext > EXW'(MAX_WIDTH)) ? (CW+1)'(MAX_WIDTH) : (CW+1)'(wext));
	assign h_eff = (hext == '0) ? (RW+1)'(1) :
		((hext > EYW'(MAX_HEIGHT)) ? (RW+1)'(MAX_HEIGHT) : (RW+1)'(hext));

	usc_seq #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.cfg_we   (cfg_we),
		.in_valid (src.valid),
		.in_ready (src.ready),
		.in_pixel (src.source_pixel),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_wlane(mem_wlane),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.tap      (tap),
		.out_pop  (pop)
	);

	usc_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wlane(mem_wlane),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	usc_filter u_filter (
		.clk      (clk),
		.arst_n   (arst_n),
		.tap      (tap),
		.rdata    (rdata),
		.res      (res),
		.res_valid(res_valid)
	);

	assign pop = dst.valid && dst.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (res_valid) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(res_valid) - FIFO_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_q] <= res;
		end
	end

	assign dst.valid      = (cnt_q != '0);
	assign dst.out_column = fifo_q[rd_q].col;
	assign dst.out_row    = fifo_q[rd_q].row;
	assign dst.out_pixel  = fifo_q[rd_q].pix;
	assign dst.run_last   = fifo_q[rd_q].run_last;

	// issue credit must keep the result queue from overflowing
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cnt_q < FIFO_CW'(FIFO_DEPTH))
		else $error("result queue overflow");

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid |-> 16'(dst.out_row) < 16'({h_eff, 1'b0}))
		else $error("output row beyond doubled frame");

	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		dst.valid |-> 16'(dst.out_column) < 16'({w_eff, 1'b0}))
		else $error("output column beyond doubled frame");

	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		tap.valid |-> !src.ready)
		else $error("input taken while reads are being issued");

endmodule
